@@ sv/two_key_sorted_priority_queue_defines.svh @@
// ----------------------------------------------------------------------------
// Two-key sorted priority queue: assertion macros
// Shared check templates, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TWO_KEY_SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define TWO_KEY_SORTED_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication
`define TKSQ_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tksq assertion failed");

// next-cycle implication
`define TKSQ_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tksq assertion failed");

`endif

@@ sv/tksq_pkg.sv @@
// ----------------------------------------------------------------------------
// Two-key sorted priority queue: package
// Payload structs, command and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
package tksq_pkg;

   localparam int OCC_W = 7;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_CLEAR  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_EMPTY = 2'd1,
      STS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [15:0] tag;
      logic [7:0]  prio;
      logic [15:0] treat;
   } entry_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] tag;
      logic [7:0]  prio;
      logic [15:0] treat;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic             out_valid;
      logic [15:0]      out_tag;
      logic [7:0]       out_prio;
      logic [15:0]      out_treat;
      logic [OCC_W-1:0] occupancy;
   } rsp_type;

   // broadcast to every cell
   typedef struct packed {
      logic insert;
      logic remove;
      logic clear;
   } ctl_type;

endpackage

@@ sv/tksq_cell.sv @@
// ----------------------------------------------------------------------------
// Two-key sorted priority queue: storage cell
// Holds one slot, compares it against the broadcast entry, and on a
// transfer keeps, loads the new entry, takes a neighbor's slot, or clears.
// ----------------------------------------------------------------------------
module tksq_cell (
   input  logic                clock,
   input  logic                reset,
   input  tksq_pkg::ctl_type   ctl,
   input  tksq_pkg::entry_type new_entry,
   input  logic                left_cond,
   input  logic                left_valid,
   input  tksq_pkg::entry_type left_entry,
   input  logic                right_valid,
   input  tksq_pkg::entry_type right_entry,
   output logic                cond,
   output logic                valid,
   output tksq_pkg::entry_type entry
);
   import tksq_pkg::*;

   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;
   logic      key_ge;

   // stored pair at or above the new one; empty slots count as above
   assign key_ge = (entry_ff.prio > new_entry.prio) ||
                   ((entry_ff.prio == new_entry.prio) &&
                    (entry_ff.treat >= new_entry.treat));
   assign cond = !valid_ff || key_ge;

   // pick next slot contents
   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.remove) begin
         valid_in = right_valid;
         entry_in = right_entry;
      end else if (ctl.insert) begin
         if (left_cond) begin
            valid_in = left_valid;
            entry_in = left_entry;
         end else if (cond) begin
            valid_in = 1'b1;
            entry_in = new_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // slot data needs no reset
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign valid = valid_ff;
   assign entry = entry_ff;

endmodule

@@ sv/two_key_sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// Two-key sorted priority queue: top level
// A chain of DEPTH cells kept sorted by (prio, treat) ascending; inserts
// shift the tail right, removes shift everything left, clear drops all.
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_stall   req_data (command, tag, prio, treat)
//   rsp      out  rsp_valid/rsp_stall   rsp_data (status, head entry, count)
//
// One command per cycle unless stalled; all cells compare and shift at once.
// Each command gives one result, registered in the cycle after its transfer.
// A stalled result holds the request side through req_stall.
// Reset clears the slot valid bits and the count; req_stall is high in reset.
// ----------------------------------------------------------------------------
`include "two_key_sorted_priority_queue_defines.svh"

module two_key_sorted_priority_queue #(
   parameter int DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tksq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tksq_pkg::rsp_type rsp_data
);
   import tksq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic             accept;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   ctl_type          ctl;
   entry_type        new_entry;
   logic             is_full, is_empty;

   logic             cell_cond  [DEPTH];
   logic             cell_valid [DEPTH];
   entry_type        cell_entry [DEPTH];

   assign req_stall = reset || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign is_empty  = (count_ff == '0);

   assign new_entry.tag   = req_data.tag;
   assign new_entry.prio  = req_data.prio;
   assign new_entry.treat = req_data.treat;

   // decode the command, build the result
   always_comb begin
      ctl          = '0;
      count_in     = count_ff;
      rsp_in       = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in.status = STS_OK;
      case (req_data.command)
         CMD_INSERT: begin
            if (is_full) begin
               rsp_in.status = STS_FULL;
            end else begin
               ctl.insert = accept;
               count_in   = count_ff + CNT_W'(1);
            end
         end
         CMD_REMOVE: begin
            if (is_empty) begin
               rsp_in.status = STS_EMPTY;
            end else begin
               ctl.remove       = accept;
               count_in         = count_ff - CNT_W'(1);
               rsp_in.out_valid = 1'b1;
               rsp_in.out_tag   = cell_entry[0].tag;
               rsp_in.out_prio  = cell_entry[0].prio;
               rsp_in.out_treat = cell_entry[0].treat;
            end
         end
         CMD_CLEAR: begin
            ctl.clear = accept;
            count_in  = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
      rsp_in.occupancy = OCC_W'(count_in);
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   // chain of cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic      l_cond, l_valid, r_valid;
      entry_type l_entry, r_entry;
      if (i == 0) begin : g_head
         assign l_cond  = 1'b0;
         assign l_valid = 1'b0;
         assign l_entry = new_entry;
      end else begin : g_body
         assign l_cond  = cell_cond[i-1];
         assign l_valid = cell_valid[i-1];
         assign l_entry = cell_entry[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign r_valid = 1'b0;
         assign r_entry = cell_entry[i];
      end else begin : g_inner
         assign r_valid = cell_valid[i+1];
         assign r_entry = cell_entry[i+1];
      end
      tksq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .new_entry   (new_entry),
         .left_cond   (l_cond),
         .left_valid  (l_valid),
         .left_entry  (l_entry),
         .right_valid (r_valid),
         .right_entry (r_entry),
         .cond        (cell_cond[i]),
         .valid       (cell_valid[i]),
         .entry       (cell_entry[i])
      );
   end

   // count and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // hold result payload while stalled
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `TKSQ_ASSERT_IMPL(a_head_matches_count, 1'b1, (count_ff == '0) == !cell_valid[0])
   `TKSQ_ASSERT_IMPL(a_tail_matches_count, 1'b1, is_full == cell_valid[DEPTH-1])
   `TKSQ_ASSERT_NEXT(a_pop_count, ctl.remove, count_ff == $past(count_ff) - CNT_W'(1))
   `TKSQ_ASSERT_NEXT(a_push_count, ctl.insert, count_ff == $past(count_ff) + CNT_W'(1))
   `TKSQ_ASSERT_NEXT(a_result_follows, accept, rsp_valid_ff)

endmodule
